FILE: rtl/core/ncbp_pkg.sv
// Shared constants, types and helpers for the n-gram cascade byte predictor.
package ncbp_pkg;

  localparam int unsigned HIST_LEN = 7;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [15:0] ORDER4_MUL = 16'd257;
  localparam logic [7:0]  CONF_SCALE = 8'd255;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  FALLBACK_BYTE = 8'd32;
  localparam int unsigned PAIR_ROW = 256;
  localparam int unsigned PAIR_DEPTH = 65536;
  localparam int unsigned NUM_TABLES = 3;

  localparam logic [1:0] SRC_ORDER8 = 2'd0;
  localparam logic [1:0] SRC_ORDER4 = 2'd1;
  localparam logic [1:0] SRC_ORDER3 = 2'd2;
  localparam logic [1:0] SRC_BIGRAM = 2'd3;

  typedef struct packed {
    logic [7:0]  tok;
    logic [15:0] cnt;
  } slot_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
  endfunction

endpackage

FILE: rtl/core/ncbp_if.sv
// Valid/ready channel interfaces for observed bytes and predictions.
interface ncbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] observed_byte;
  modport source (output valid, output observed_byte, input ready);
  modport sink (input valid, input observed_byte, output ready);
endinterface

interface ncbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] predicted_byte;
  logic [7:0] confidence;
  logic       hit;
  logic [1:0] source_order;
  modport source (output valid, output predicted_byte, output confidence, output hit,
                  output source_order, input ready);
  modport sink (input valid, input predicted_byte, input confidence, input hit,
                input source_order, output ready);
endinterface

FILE: rtl/core/ncbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ncbp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/ncbp_queue.sv
// Two-entry queue between the front end and the back end.
module ncbp_queue #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] buf_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end
endmodule

FILE: rtl/core/ncbp_front.sv
// Front end: accepts bytes, keeps the history and forms the three bucket indexes.
module ncbp_front #(
  parameter int unsigned BKT_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ncbp_in_if.sink               in_i,
  input  logic                  hold_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [16+3*BKT_W-1:0] item_o
);
  import ncbp_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e     state_q;
  logic [7:0]  hist_q [HIST_LEN];
  logic [7:0]  snap_q [HIST_LEN];
  logic [7:0]  obs_q;
  logic [31:0] h_q;
  logic [2:0]  step_q;
  logic [2:0]  sel;
  logic [31:0] hx;
  logic [15:0] o3;
  logic [15:0] o4;
  logic [15:0] o8;

  assign in_i.ready = (state_q == F_IDLE) && !hold_i;
  assign sel = 3'(HIST_LEN - 1) - step_q;
  assign hx  = h_q ^ {24'd0, snap_q[sel]};
  assign o3  = {snap_q[1], snap_q[0]};
  assign o4  = 16'(16'(snap_q[2]) * ORDER4_MUL) ^ {snap_q[1], 8'd0} ^ {8'd0, snap_q[0]};
  assign o8  = h_q[15:0] ^ h_q[31:16];
  assign push_o = (state_q == F_PUSH) && !full_i;
  assign item_o = {obs_q, snap_q[0], o8[BKT_W-1:0], o4[BKT_W-1:0], o3[BKT_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      snap_q <= hist_q;
      obs_q  <= in_i.observed_byte;
      h_q    <= FNV_BASIS;
    end else if (state_q == F_HASH) begin
      h_q <= 32'(hx * FNV_PRIME);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 3'd0;
      for (int k = 0; k < HIST_LEN; k++) begin
        hist_q[k] <= 8'd0;
      end
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            for (int k = HIST_LEN - 1; k > 0; k--) begin
              hist_q[k] <= hist_q[k-1];
            end
            hist_q[0] <= in_i.observed_byte;
            step_q    <= 3'd0;
            state_q   <= F_HASH;
          end
        end
        F_HASH: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'(HIST_LEN - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/ncbp_back.sv
// Back end: clears the tables, scans buckets and the pair row, divides and trains.
module ncbp_back #(
  parameter int unsigned SLOTS_PER_BUCKET = 16,
  parameter int unsigned CONTEXT_BUCKETS  = 65536
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [16+3*$clog2(CONTEXT_BUCKETS)-1:0]    item_i,
  input  logic                                       empty_i,
  output logic                                       pop_o,
  output logic                                       clr_busy_o,
  ncbp_out_if.source                                 out_o
);
  import ncbp_pkg::*;

  localparam int unsigned BKT_W     = $clog2(CONTEXT_BUCKETS);
  localparam int unsigned SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned SCNT_W    = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned TAB_DEPTH = CONTEXT_BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned TAB_AW    = $clog2(TAB_DEPTH);
  localparam int unsigned PAIR_AW   = $clog2(PAIR_DEPTH);
  localparam int unsigned CLR_DEPTH = (TAB_DEPTH > PAIR_DEPTH) ? TAB_DEPTH : PAIR_DEPTH;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [6:0] {
    B_CLEAR = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_SCAN  = 7'b0000100,
    B_PAIR  = 7'b0001000,
    B_SEL   = 7'b0010000,
    B_DIV   = 7'b0100000,
    B_OUT   = 7'b1000000
  } bstate_e;

  bstate_e            state_q;
  logic [CLR_W-1:0]   clr_q;
  logic [7:0]         obs_q;
  logic [7:0]         t1_q;
  logic [BKT_W-1:0]   idx_q   [NUM_TABLES];
  logic [SCNT_W-1:0]  iss_q;
  logic [SCNT_W-1:0]  prc_q;
  logic               rvld_q;
  logic [23:0]        tot_q   [NUM_TABLES];
  logic [15:0]        top_q   [NUM_TABLES];
  logic [7:0]         pick_q  [NUM_TABLES];
  logic               mfnd_q  [NUM_TABLES];
  logic [SLOT_W-1:0]  mi_q    [NUM_TABLES];
  logic [15:0]        mc_q    [NUM_TABLES];
  logic               ffnd_q  [NUM_TABLES];
  logic [SLOT_W-1:0]  fi_q    [NUM_TABLES];
  logic [SLOT_W-1:0]  mini_q  [NUM_TABLES];
  logic [15:0]        minc_q  [NUM_TABLES];
  logic [7:0]         mint_q  [NUM_TABLES];
  logic [8:0]         piss_q;
  logic [8:0]         pprc_q;
  logic               prvld_q;
  logic               prow_q;
  logic [23:0]        ptot_q;
  logic [15:0]        ptop_q;
  logic [7:0]         ppred_q;
  logic [15:0]        pcnt_q;
  logic [7:0]         pred_q;
  logic [1:0]         src_q;
  logic [23:0]        den_q;
  logic [24:0]        rem_q;
  logic [7:0]         num_lo_q;
  logic [7:0]         quo_q;
  logic [3:0]         dstep_q;
  logic               out_vld_q;
  logic [7:0]         out_pred_q;
  logic [7:0]         out_conf_q;
  logic               out_hit_q;
  logic [1:0]         out_src_q;

  logic               clearing;
  logic               load_out;
  logic               row_full;
  logic [TAB_AW-1:0]  tab_raddr [NUM_TABLES];
  logic [TAB_AW-1:0]  tab_waddr [NUM_TABLES];
  logic [23:0]        tab_wdata [NUM_TABLES];
  logic [23:0]        tab_rdata [NUM_TABLES];
  logic               tab_we;
  logic [PAIR_AW-1:0] pair_raddr;
  logic [PAIR_AW-1:0] pair_waddr;
  logic [15:0]        pair_wdata;
  logic [15:0]        pair_rdata;
  logic               pair_we;
  logic [SLOT_W-1:0]  trn_i     [NUM_TABLES];
  slot_t              trn_d     [NUM_TABLES];
  logic [15:0]        sel_top;
  logic [23:0]        sel_tot;
  logic [23:0]        num;
  logic [24:0]        rem_sh;

  assign clearing   = (state_q == B_CLEAR);
  assign clr_busy_o = clearing;
  assign pop_o      = (state_q == B_IDLE) && !empty_i;
  assign load_out   = (state_q == B_OUT) && (!out_vld_q || out_o.ready);
  assign row_full   = (tot_q[0] == 24'd0) && (tot_q[1] == 24'd0) && (tot_q[2] == 24'd0);

  always_comb begin
    for (int j = 0; j < NUM_TABLES; j++) begin
      if (mfnd_q[j]) begin
        trn_i[j] = mi_q[j];
        trn_d[j] = '{tok: obs_q, cnt: sat_inc(mc_q[j])};
      end else if (ffnd_q[j]) begin
        trn_i[j] = fi_q[j];
        trn_d[j] = '{tok: obs_q, cnt: 16'd1};
      end else if (minc_q[j] > 16'd1) begin
        trn_i[j] = mini_q[j];
        trn_d[j] = '{tok: mint_q[j], cnt: minc_q[j] - 16'd1};
      end else begin
        trn_i[j] = mini_q[j];
        trn_d[j] = '{tok: obs_q, cnt: 16'd1};
      end
      tab_raddr[j] = TAB_AW'(idx_q[j]) * TAB_AW'(SLOTS_PER_BUCKET) + TAB_AW'(iss_q);
      tab_waddr[j] = clearing ? clr_q[TAB_AW-1:0]
                   : TAB_AW'(idx_q[j]) * TAB_AW'(SLOTS_PER_BUCKET) + TAB_AW'(trn_i[j]);
      tab_wdata[j] = clearing ? 24'd0 : trn_d[j];
    end
  end

  assign tab_we     = (clearing && ({1'b0, clr_q} < (CLR_W+1)'(TAB_DEPTH))) || load_out;
  assign pair_raddr = row_full ? {t1_q, piss_q[7:0]} : {t1_q, obs_q};
  assign pair_waddr = clearing ? clr_q[PAIR_AW-1:0] : {t1_q, obs_q};
  assign pair_wdata = clearing ? 16'd0 : sat_inc(pcnt_q);
  assign pair_we    = (clearing && ({1'b0, clr_q} < (CLR_W+1)'(PAIR_DEPTH))) || load_out;

  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_tab
    ncbp_ram #(.WIDTH(24), .DEPTH(TAB_DEPTH)) u_tab (
      .clk_i   (clk_i),
      .we_i    (tab_we),
      .waddr_i (tab_waddr[g]),
      .wdata_i (tab_wdata[g]),
      .raddr_i (tab_raddr[g]),
      .rdata_o (tab_rdata[g])
    );
  end

  ncbp_ram #(.WIDTH(16), .DEPTH(PAIR_DEPTH)) u_pair (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (pair_waddr),
    .wdata_i (pair_wdata),
    .raddr_i (pair_raddr),
    .rdata_o (pair_rdata)
  );

  always_comb begin
    if (tot_q[0] != 24'd0) begin
      sel_top = top_q[0];
      sel_tot = tot_q[0];
    end else if (tot_q[1] != 24'd0) begin
      sel_top = top_q[1];
      sel_tot = tot_q[1];
    end else if (tot_q[2] != 24'd0) begin
      sel_top = top_q[2];
      sel_tot = tot_q[2];
    end else begin
      sel_top = ptop_q;
      sel_tot = ptot_q;
    end
  end

  assign num    = 24'(sel_top) * 24'(CONF_SCALE);
  assign rem_sh = {rem_q[23:0], num_lo_q[7]};

  assign out_o.valid          = out_vld_q;
  assign out_o.predicted_byte = out_pred_q;
  assign out_o.confidence     = out_conf_q;
  assign out_o.hit            = out_hit_q;
  assign out_o.source_order   = out_src_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          {obs_q, t1_q, idx_q[0], idx_q[1], idx_q[2]} <= item_i;
          for (int j = 0; j < NUM_TABLES; j++) begin
            tot_q[j]  <= 24'd0;
            top_q[j]  <= 16'd0;
            pick_q[j] <= 8'd0;
            mfnd_q[j] <= 1'b0;
            ffnd_q[j] <= 1'b0;
            mini_q[j] <= '0;
            minc_q[j] <= COUNT_MAX;
          end
          ptot_q  <= 24'd0;
          ptop_q  <= 16'd0;
          ppred_q <= FALLBACK_BYTE;
        end
      end
      B_SCAN: begin
        if (rvld_q) begin
          for (int j = 0; j < NUM_TABLES; j++) begin
            automatic slot_t s = tab_rdata[j];
            tot_q[j] <= tot_q[j] + 24'(s.cnt);
            if (s.cnt > top_q[j]) begin
              top_q[j]  <= s.cnt;
              pick_q[j] <= s.tok;
            end
            if (s.cnt == 16'd0 && !ffnd_q[j]) begin
              ffnd_q[j] <= 1'b1;
              fi_q[j]   <= prc_q[SLOT_W-1:0];
            end
            if (s.cnt != 16'd0 && s.tok == obs_q && !mfnd_q[j]) begin
              mfnd_q[j] <= 1'b1;
              mi_q[j]   <= prc_q[SLOT_W-1:0];
              mc_q[j]   <= s.cnt;
            end
            if (s.cnt < minc_q[j]) begin
              minc_q[j] <= s.cnt;
              mini_q[j] <= prc_q[SLOT_W-1:0];
              mint_q[j] <= s.tok;
            end else if (prc_q == '0) begin
              mint_q[j] <= s.tok;
            end
          end
        end
      end
      B_PAIR: begin
        if (prvld_q) begin
          if (prow_q) begin
            ptot_q <= ptot_q + 24'(pair_rdata);
            if (pair_rdata > ptop_q) begin
              ptop_q  <= pair_rdata;
              ppred_q <= pprc_q[7:0];
            end
            if (pprc_q[7:0] == obs_q) begin
              pcnt_q <= pair_rdata;
            end
          end else begin
            pcnt_q <= pair_rdata;
          end
        end
      end
      B_SEL: begin
        den_q    <= sel_tot;
        rem_q    <= {9'd0, num[23:8]};
        num_lo_q <= num[7:0];
        quo_q    <= 8'd0;
        if (tot_q[0] != 24'd0) begin
          pred_q <= pick_q[0];
          src_q  <= SRC_ORDER8;
        end else if (tot_q[1] != 24'd0) begin
          pred_q <= pick_q[1];
          src_q  <= SRC_ORDER4;
        end else if (tot_q[2] != 24'd0) begin
          pred_q <= pick_q[2];
          src_q  <= SRC_ORDER3;
        end else begin
          pred_q <= ppred_q;
          src_q  <= SRC_BIGRAM;
        end
      end
      B_DIV: begin
        num_lo_q <= {num_lo_q[6:0], 1'b0};
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[6:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_pred_q <= pred_q;
      out_conf_q <= (den_q == 24'd0) ? 8'd0 : quo_q;
      out_hit_q  <= (pred_q == obs_q);
      out_src_q  <= src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLEAR;
      clr_q     <= '0;
      iss_q     <= '0;
      prc_q     <= '0;
      rvld_q    <= 1'b0;
      piss_q    <= 9'd0;
      pprc_q    <= 9'd0;
      prvld_q   <= 1'b0;
      prow_q    <= 1'b0;
      dstep_q   <= 4'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_o.ready && !load_out) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            iss_q   <= '0;
            prc_q   <= '0;
            rvld_q  <= 1'b0;
            state_q <= B_SCAN;
          end
        end
        B_SCAN: begin
          rvld_q <= (iss_q < SCNT_W'(SLOTS_PER_BUCKET));
          if (iss_q < SCNT_W'(SLOTS_PER_BUCKET)) begin
            iss_q <= iss_q + SCNT_W'(1);
          end
          if (rvld_q) begin
            prc_q <= prc_q + SCNT_W'(1);
            if (prc_q == SCNT_W'(SLOTS_PER_BUCKET - 1)) begin
              piss_q  <= 9'd0;
              pprc_q  <= 9'd0;
              prvld_q <= 1'b0;
              state_q <= B_PAIR;
            end
          end
        end
        B_PAIR: begin
          prow_q  <= row_full;
          prvld_q <= (piss_q < (row_full ? 9'(PAIR_ROW) : 9'd1));
          if (piss_q < (row_full ? 9'(PAIR_ROW) : 9'd1)) begin
            piss_q <= piss_q + 9'd1;
          end
          if (prvld_q) begin
            pprc_q <= pprc_q + 9'd1;
            if (pprc_q == (prow_q ? 9'(PAIR_ROW - 1) : 9'd0)) begin
              state_q <= B_SEL;
            end
          end
        end
        B_SEL: begin
          dstep_q <= 4'd0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          dstep_q <= dstep_q + 4'd1;
          if (dstep_q == 4'd7) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (load_out) begin
            out_vld_q <= 1'b1;
            state_q   <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/ngram_cascade_byte_predictor_unit.sv
// Top level of the n-gram cascade byte predictor.
//
// in_i carries one observed byte per transfer; out_o returns exactly one
// prediction per byte, in order: the byte guessed from the seven earlier
// bytes, its confidence, a hit flag and the table that supplied it.
// The front end hashes the history and hands the item to a
// two-entry queue; the back end reads the three buckets in parallel, one
// slot a cycle, reads the pair row, divides and trains.
// When all three buckets are empty the back end scans the whole 256-entry
// pair row, otherwise only one entry of it; the back end sets the rate.
// After reset a clearing pass writes zero to every table, one entry a cycle
// over max(65536, CONTEXT_BUCKETS * SLOTS_PER_BUCKET) addresses (1048576 at
// the defaults); in_i.ready stays low until it ends.
// A result waits in the output register while the receiver stalls; the
// front end keeps taking bytes until the queue fills.
module ngram_cascade_byte_predictor_unit #(
  parameter int unsigned SLOTS_PER_BUCKET = 16,
  parameter int unsigned CONTEXT_BUCKETS  = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ncbp_in_if.sink    in_i,
  ncbp_out_if.source out_o
);
  import ncbp_pkg::*;

  localparam int unsigned BKT_W  = $clog2(CONTEXT_BUCKETS);
  localparam int unsigned ITEM_W = 16 + NUM_TABLES * BKT_W;

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  logic              clr_busy;
  logic [ITEM_W-1:0] front_item;
  logic [ITEM_W-1:0] back_item;

  ncbp_front #(.BKT_W(BKT_W)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .hold_i (clr_busy),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  ncbp_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (back_item)
  );

  ncbp_back #(
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .CONTEXT_BUCKETS  (CONTEXT_BUCKETS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (back_item),
    .empty_i    (empty),
    .pop_o      (pop),
    .clr_busy_o (clr_busy),
    .out_o      (out_o)
  );
endmodule
